@@ rtl/core/rrd_pkg.sv @@
package rrd_pkg;

  typedef enum logic [2:0] {
    CMD_ENQUEUE = 3'd0,
    CMD_DEQUEUE = 3'd1,
    CMD_FRONT   = 3'd2,
    CMD_REAR    = 3'd3,
    CMD_REVERSE = 3'd4,
    CMD_ROTATE  = 3'd5,
    CMD_READ_AT = 3'd6,
    CMD_NEXT_OF = 3'd7
  } rrd_cmd_e;

  localparam int unsigned EntryW = 32;
  localparam int unsigned PosW   = 4;
  localparam int unsigned OccW   = 5;

  typedef struct packed {
    rrd_cmd_e            command;
    logic [EntryW-1:0]   entry_in;
    logic [PosW-1:0]     position;
  } rrd_in_t;

  typedef struct packed {
    logic                ok;
    logic [EntryW-1:0]   entry_out;
    logic [PosW-1:0]     next_position;
    logic [OccW-1:0]     occupancy;
    logic                clockwise;
  } rrd_out_t;

endpackage

@@ rtl/core/rrd_ring_mem.sv @@
module rrd_ring_mem #(
  parameter int unsigned DEPTH  = 16,
  parameter int unsigned DATA_W = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [DATA_W-1:0]        wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [DATA_W-1:0]        rdata_o
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/core/reversible_rotating_deque.sv @@
// channel  | handshake              | payload
// ---------+------------------------+---------------------------
// in       | in_valid_i / in_stall_o  | in_data_i  (rrd_in_t)
// out      | out_valid_o / out_stall_i| out_data_o (rrd_out_t)
//
// Each item passes through ST_IDLE and ST_RESP: the ring memory is read (or written) at the
// accept edge, and in ST_RESP its registered read data forms the result.
// Rotate writes the moved entry back as ST_RESP finishes.
// Reset clears head, count and direction (clockwise); ring contents stay
// undefined until written.
// A result held by out_stall_i keeps the block from finishing the next item.
module reversible_rotating_deque #(
  parameter int unsigned CAPACITY   = 16,
  parameter int unsigned ENTRY_BITS = 32
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  rrd_pkg::rrd_in_t  in_data_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output rrd_pkg::rrd_out_t out_data_o
);
  import rrd_pkg::*;

  localparam int unsigned PtrW   = $clog2(CAPACITY);
  localparam int unsigned CntW   = $clog2(CAPACITY + 1);
  localparam int unsigned OffW   = (CntW > PosW) ? CntW : PosW;
  localparam int unsigned SumW   = OffW + 1;
  localparam int unsigned StoreW = (ENTRY_BITS < EntryW) ? ENTRY_BITS : EntryW;

  typedef enum logic {
    ST_IDLE,
    ST_RESP
  } state_e;

  state_e              state_q;
  logic [PtrW-1:0]     head_q, head_d;
  logic [CntW-1:0]     count_q, count_d;
  logic                dir_q, dir_d;

  logic                pend_ok_q, pend_ok_d;
  logic                pend_take_q, pend_take_d;
  logic [PosW-1:0]     pend_next_q, pend_next_d;
  logic                wb_q, wb_d;
  logic [PtrW-1:0]     wb_addr_q, wb_addr_d;

  logic                out_valid_q;
  rrd_out_t            out_data_q;
  rrd_out_t            result;

  logic                accept;
  logic                finish;
  logic                empty, full, pos_ok;
  logic [OffW-1:0]     pos_ext, cnt_ext, pos_inc, nb;

  logic                mem_we, mem_re;
  logic [PtrW-1:0]     mem_waddr, mem_raddr;
  logic [StoreW-1:0]   mem_wdata, mem_rdata;

  function automatic logic [PtrW-1:0] slot_of(logic [PtrW-1:0] head, logic [OffW-1:0] off);
    logic [SumW-1:0] sum;
    sum = SumW'(head) + SumW'(off);
    if (sum >= SumW'(CAPACITY)) begin
      return PtrW'(sum - SumW'(CAPACITY));
    end
    return PtrW'(sum);
  endfunction

  assign accept     = in_valid_i && (state_q == ST_IDLE);
  assign in_stall_o = (state_q != ST_IDLE);
  assign finish     = (state_q == ST_RESP) && (!out_valid_q || !out_stall_i);

  assign empty   = (count_q == '0);
  assign full    = (count_q == CntW'(CAPACITY));
  assign pos_ext = OffW'(in_data_i.position);
  assign cnt_ext = OffW'(count_q);
  assign pos_ok  = (pos_ext < cnt_ext);
  assign pos_inc = pos_ext + OffW'(1);

  // neighbor index in the current direction, wrapping inside the held entries
  always_comb begin
    if (dir_q) begin
      nb = (pos_inc < cnt_ext) ? pos_inc : '0;
    end else begin
      nb = (pos_ext != '0) ? pos_ext - OffW'(1) : cnt_ext - OffW'(1);
    end
  end

  always_comb begin
    head_d      = head_q;
    count_d     = count_q;
    dir_d       = dir_q;
    pend_ok_d   = 1'b0;
    pend_take_d = 1'b0;
    pend_next_d = '0;
    wb_d        = 1'b0;
    wb_addr_d   = wb_addr_q;
    mem_re      = 1'b0;
    mem_raddr   = head_q;
    mem_we      = 1'b0;
    mem_waddr   = slot_of(head_q, cnt_ext);
    mem_wdata   = StoreW'(in_data_i.entry_in);

    unique case (in_data_i.command)
      CMD_ENQUEUE: begin
        pend_ok_d = !full;
        mem_we    = accept && !full;
        if (!full) begin
          count_d = count_q + CntW'(1);
        end
      end
      CMD_DEQUEUE: begin
        pend_ok_d   = !empty;
        pend_take_d = !empty;
        mem_re      = accept;
        if (!empty) begin
          head_d  = slot_of(head_q, OffW'(1));
          count_d = count_q - CntW'(1);
        end
      end
      CMD_FRONT: begin
        pend_ok_d   = !empty;
        pend_take_d = !empty;
        mem_re      = accept;
      end
      CMD_REAR: begin
        pend_ok_d   = !empty;
        pend_take_d = !empty;
        mem_re      = accept;
        mem_raddr   = slot_of(head_q, cnt_ext - OffW'(1));
      end
      CMD_REVERSE: begin
        pend_ok_d = 1'b1;
        dir_d     = !dir_q;
      end
      CMD_ROTATE: begin
        pend_ok_d = !empty;
        if (count_q > CntW'(1)) begin
          wb_d   = 1'b1;
          mem_re = accept;
          if (dir_q) begin
            mem_raddr = head_q;
            wb_addr_d = slot_of(head_q, cnt_ext);
            head_d    = slot_of(head_q, OffW'(1));
          end else begin
            mem_raddr = slot_of(head_q, cnt_ext - OffW'(1));
            wb_addr_d = slot_of(head_q, OffW'(CAPACITY - 1));
            head_d    = slot_of(head_q, OffW'(CAPACITY - 1));
          end
        end
      end
      CMD_READ_AT: begin
        pend_ok_d   = pos_ok;
        pend_take_d = pos_ok;
        mem_re      = accept;
        mem_raddr   = slot_of(head_q, pos_ext);
      end
      CMD_NEXT_OF: begin
        pend_ok_d   = pos_ok;
        pend_take_d = pos_ok;
        pend_next_d = pos_ok ? PosW'(nb) : '0;
        mem_re      = accept;
        mem_raddr   = slot_of(head_q, nb);
      end
      default: begin
      end
    endcase

    // write the rotated entry back once its read data is in
    if (finish && wb_q) begin
      mem_we    = 1'b1;
      mem_waddr = wb_addr_q;
      mem_wdata = mem_rdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      count_q     <= '0;
      dir_q       <= 1'b1;
      pend_ok_q   <= 1'b0;
      pend_take_q <= 1'b0;
      pend_next_q <= '0;
      wb_q        <= 1'b0;
      wb_addr_q   <= '0;
    end else if (accept) begin
      head_q      <= head_d;
      count_q     <= count_d;
      dir_q       <= dir_d;
      pend_ok_q   <= pend_ok_d;
      pend_take_q <= pend_take_d;
      pend_next_q <= pend_next_d;
      wb_q        <= wb_d;
      wb_addr_q   <= wb_addr_d;
    end
  end

  always_comb begin
    result.ok            = pend_ok_q;
    result.entry_out     = pend_take_q ? EntryW'(mem_rdata) : '0;
    result.next_position = pend_next_q;
    result.occupancy     = OccW'(count_q);
    result.clockwise     = dir_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            state_q <= ST_RESP;
          end
          if (out_valid_q && !out_stall_i) begin
            out_valid_q <= 1'b0;
          end
        end
        ST_RESP: begin
          if (finish) begin
            state_q     <= ST_IDLE;
            out_valid_q <= 1'b1;
            out_data_q  <= result;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  rrd_ring_mem #(
    .DEPTH  (CAPACITY),
    .DATA_W (StoreW)
  ) u_ring_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q <= CntW'(CAPACITY)) && (CntW'(head_q) < CntW'(CAPACITY)))
    else $error("deque pointer or count out of range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == ST_RESP))
    else $error("accepted item did not reach response state");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == ST_RESP))
    else $error("result raised without a pending item");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.ok |-> (out_data_o.entry_out == '0)
      && (out_data_o.next_position == '0))
    else $error("failed command carries nonzero payload");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (finish && wb_q) |-> !accept)
    else $error("rotate write back overlaps a new item");

endmodule

@@ dv/reversible_rotating_deque_tb.sv @@
`timescale 1ns / 100ps

module reversible_rotating_deque_tb;
  import rrd_pkg::*;

  localparam int unsigned RingDepth = 16;
  localparam int unsigned StallLimit = 4000;
  localparam int unsigned TailCycles = 12;
  localparam int unsigned RandomItems = 500;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_PERIODIC
  } stall_mode_e;

  typedef enum logic [1:0] {
    SEQ_FILL,
    SEQ_DRAIN,
    SEQ_MIXED,
    SEQ_NOISE
  } seq_kind_e;

  class deque_scoreboard;
    logic [EntryW-1:0] ring [RingDepth];
    int unsigned head;
    int unsigned count;
    bit clockwise;
    rrd_out_t expected [$];
    int unsigned errors;
    int unsigned results_seen;

    function new();
      foreach (ring[i]) ring[i] = '0;
      head = 0;
      count = 0;
      clockwise = 1'b1;
      errors = 0;
      results_seen = 0;
    endfunction

    function int unsigned slot(int unsigned offset);
      return (head + offset) % RingDepth;
    endfunction

    // Work out the result of one accepted item and advance the deque state.
    function void note_item(rrd_in_t item);
      rrd_out_t res;
      int unsigned nb;
      logic [EntryW-1:0] moved;
      res = '0;
      case (item.command)
        CMD_ENQUEUE: begin
          if (count < RingDepth) begin
            ring[slot(count)] = item.entry_in;
            count++;
            res.ok = 1'b1;
          end
        end
        CMD_DEQUEUE: begin
          if (count > 0) begin
            res.entry_out = ring[head];
            head = slot(1);
            count--;
            res.ok = 1'b1;
          end
        end
        CMD_FRONT: begin
          if (count > 0) begin
            res.entry_out = ring[head];
            res.ok = 1'b1;
          end
        end
        CMD_REAR: begin
          if (count > 0) begin
            res.entry_out = ring[slot(count - 1)];
            res.ok = 1'b1;
          end
        end
        CMD_REVERSE: begin
          clockwise = !clockwise;
          res.ok = 1'b1;
        end
        CMD_ROTATE: begin
          if (count > 0) begin
            res.ok = 1'b1;
            if (count > 1) begin
              if (clockwise) begin
                moved = ring[head];
                ring[slot(count)] = moved;
                head = slot(1);
              end else begin
                moved = ring[slot(count - 1)];
                head = slot(RingDepth - 1);
                ring[head] = moved;
              end
            end
          end
        end
        CMD_READ_AT: begin
          if (item.position < count) begin
            res.entry_out = ring[slot(item.position)];
            res.ok = 1'b1;
          end
        end
        default: begin
          if (item.position < count) begin
            if (clockwise) nb = (item.position + 1 < count) ? item.position + 1 : 0;
            else nb = (item.position > 0) ? item.position - 1 : count - 1;
            res.entry_out = ring[slot(nb)];
            res.next_position = PosW'(nb);
            res.ok = 1'b1;
          end
        end
      endcase
      res.occupancy = OccW'(count);
      res.clockwise = clockwise;
      expected.push_back(res);
    endfunction

    task report(string msg);
      $display("[%0t] mismatch on result %0d: %s", $realtime, results_seen, msg);
      errors++;
    endtask

    task check_field(string name, logic [EntryW-1:0] got, logic [EntryW-1:0] want);
      if (got !== want) report($sformatf("%s got %0h want %0h", name, got, want));
    endtask

    task check_result(rrd_out_t got);
      rrd_out_t want;
      if (expected.size() == 0) begin
        report("result with no item waiting");
      end else begin
        want = expected.pop_front();
        check_field("ok", EntryW'(got.ok), EntryW'(want.ok));
        check_field("entry_out", got.entry_out, want.entry_out);
        check_field("next_position", EntryW'(got.next_position),
                    EntryW'(want.next_position));
        check_field("occupancy", EntryW'(got.occupancy), EntryW'(want.occupancy));
        check_field("clockwise", EntryW'(got.clockwise), EntryW'(want.clockwise));
      end
      results_seen++;
    endtask
  endclass

  logic clk;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  rrd_in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  rrd_out_t out_data;

  deque_scoreboard sb;
  int unsigned idle_cycles = 0;
  int unsigned burst_left = 0;
  int unsigned fill_level = 0;
  stall_mode_e stall_mode = STALL_NONE;
  int unsigned stall_left = 0;

  reversible_rotating_deque #(
    .CAPACITY  (RingDepth),
    .ENTRY_BITS(EntryW)
  ) i_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Receiver: switch between stall patterns at random.
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_mode <= STALL_NONE;
      stall_left <= 0;
    end else begin
      if (stall_left == 0) begin
        stall_mode <= stall_mode_e'($urandom_range(0, 3));
        stall_left <= $urandom_range(16, 160);
      end else begin
        stall_left <= stall_left - 1;
      end
      case (stall_mode)
        STALL_NONE:  out_stall <= 1'b0;
        STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
        STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
        default:     out_stall <= (stall_left[2:0] < 3'd3);
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) sb.check_result(out_data);
      if (in_valid && !in_stall) sb.note_item(in_data);
      if ((out_valid && !out_stall) || (in_valid && !in_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    while (idle_cycles < StallLimit) @(posedge clk);
    $display("CHECKS FAILED");
    $finish;
  end

  // Hold the item until accepted; open a gap between bursts.
  task automatic send_item(rrd_in_t item);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 10);
    end
    burst_left--;
    in_data <= item;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic issue(rrd_cmd_e cmd, logic [EntryW-1:0] value, logic [PosW-1:0] pos);
    rrd_in_t item;
    item.command = cmd;
    item.entry_in = value;
    item.position = pos;
    send_item(item);
    if (cmd == CMD_ENQUEUE && fill_level < RingDepth) fill_level++;
    if (cmd == CMD_DEQUEUE && fill_level > 0) fill_level--;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (sb.expected.size() != 0) @(posedge clk);
  endtask

  function automatic rrd_cmd_e side_command();
    return rrd_cmd_e'($urandom_range(2, 7));
  endfunction

  task automatic random_item(seq_kind_e kind);
    int unsigned roll;
    rrd_cmd_e cmd;
    logic [EntryW-1:0] value;
    logic [PosW-1:0] pos;
    roll = $urandom_range(0, 99);
    case (kind)
      SEQ_FILL:  cmd = (roll < 55) ? CMD_ENQUEUE : side_command();
      SEQ_DRAIN: cmd = (roll < 50) ? CMD_DEQUEUE : side_command();
      default:   cmd = rrd_cmd_e'($urandom_range(0, 7));
    endcase
    case ($urandom_range(0, 15))
      0:       value = '0;
      1:       value = '1;
      default: value = $urandom;
    endcase
    if (kind != SEQ_NOISE && fill_level > 0 && $urandom_range(0, 99) < 85)
      pos = PosW'($urandom_range(0, fill_level - 1));
    else
      pos = PosW'($urandom_range(0, 15));
    issue(cmd, value, pos);
  endtask

  initial begin
    int unsigned sent;
    int unsigned seq_len;
    int unsigned seq_idx;
    int unsigned roll;
    seq_kind_e kind;
    sb = new();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty deque: every command that needs an entry fails.
    issue(CMD_DEQUEUE, '1, '0);
    issue(CMD_FRONT, '0, '0);
    issue(CMD_REAR, '0, '0);
    issue(CMD_ROTATE, '0, '0);
    issue(CMD_READ_AT, '0, '0);
    issue(CMD_NEXT_OF, '0, '1);
    issue(CMD_ENQUEUE, '1, '0);
    // Rotate with a single entry leaves it in place.
    issue(CMD_ROTATE, '0, '0);
    issue(CMD_ENQUEUE, '0, '0);
    while (fill_level < RingDepth) issue(CMD_ENQUEUE, $urandom, '0);
    // Full ring rejects the enqueue.
    issue(CMD_ENQUEUE, 32'h5a5a_a5a5, '0);
    issue(CMD_NEXT_OF, '0, '1);
    issue(CMD_REVERSE, '0, '0);
    issue(CMD_NEXT_OF, '0, '0);
    issue(CMD_ROTATE, '0, '0);
    issue(CMD_READ_AT, '0, '1);
    wait_drained();

    sent = 0;
    seq_idx = 0;
    while (sent < RandomItems) begin
      roll = $urandom_range(0, 99);
      if (roll < 30) kind = SEQ_FILL;
      else if (roll < 60) kind = SEQ_DRAIN;
      else if (roll < 90) kind = SEQ_MIXED;
      else kind = SEQ_NOISE;
      seq_len = $urandom_range(8, 40);
      repeat (seq_len) begin
        random_item(kind);
        sent++;
      end
      if (seq_idx % 5 == 2) wait_drained();
      seq_idx++;
    end

    wait_drained();
    repeat (TailCycles) @(posedge clk);
    if (sb.errors == 0 && sb.expected.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
